// ===== hw/rtl/wsfd_pkg.sv =====
// Shared types and codes for the WebSocket frame deframer.
// Used by wsfd_parser, wsfd_out_reg and websocket_frame_deframer. No dependencies.
package wsfd_pkg;

   // Width of the length and remaining-byte counters
   localparam int unsigned LEN_W = 64;

   // Length codes that announce an extended length
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   // Extension byte counts for the two extended length forms
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   // Opcodes accepted in a frame header
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_PAY  = 3'd4,
      PH_HALT = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      kind_type   kind;
      logic [3:0] frame_opcode;
      logic       final_fragment;
      logic       last_of_frame;
   } result_type;

   function automatic logic opcode_known(input logic [3:0] op);
      return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
             (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
   endfunction

endpackage

// ===== hw/rtl/websocket_frame_deframer.sv =====
// WebSocket client-to-server frame deframer, one stream byte per transaction.
//
// Input channel req_*: one byte (req_data_byte) or an end-of-stream mark
// (req_end_of_stream) per transaction, accepted when req_valid is high and
// req_stall is low. Result channel rsp_*: at most one result per input byte:
// an unmasked payload byte, an empty-frame mark, a protocol error or a close,
// taken when rsp_valid is high and rsp_stall is low.
// A result passes the input register, then the result register. Throughput:
// one byte per cycle while the result channel does not stall, set by the
// single-pass parser state update and the XOR unmask between the two
// registers; header, length and key bytes that yield no result never wait.
// When the receiver stalls, the result register holds its transaction; the
// input register still drains bytes that yield no result, and req_stall rises
// only when a byte that yields a result finds the result register full.
// Reset (synchronous, active high) empties both registers and returns the
// parser to expect a first header byte. After an error or close result, all
// further input is accepted and dropped until reset.
// Depends on wsfd_pkg, wsfd_parser and wsfd_out_reg.
module websocket_frame_deframer import wsfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic [1:0] rsp_kind,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_final_fragment,
   output logic       rsp_last_of_frame
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_eos_ff;
   logic       req_take;
   logic       advance;
   logic       result_want;
   logic       out_free;
   result_type result;
   result_type rsp_result;

   // Consume the held transaction unless its result has nowhere to go
   assign advance     = in_valid_ff && (!result_want || out_free);
   assign req_stall   = in_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   wsfd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .data_byte     (in_data_ff),
      .end_of_stream (in_eos_ff),
      .result_want   (result_want),
      .result        (result)
   );

   wsfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result_want),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_payload_byte   = rsp_result.payload_byte;
   assign rsp_kind           = rsp_result.kind;
   assign rsp_frame_opcode   = rsp_result.frame_opcode;
   assign rsp_final_fragment = rsp_result.final_fragment;
   assign rsp_last_of_frame  = rsp_result.last_of_frame;

   // Error and close results never carry a frame-end mark or payload
   a_term_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_kind == KIND_ERROR) || (rsp_kind == KIND_CLOSE)))
      |-> (!rsp_last_of_frame && (rsp_payload_byte == 8'd0)))
      else $error("error or close result with frame data");

endmodule

// ===== hw/rtl/wsfd_parser.sv =====
// Frame parsing state machine: header check, length, masking key, payload unmask.
// Depends on wsfd_pkg.
module wsfd_parser import wsfd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  logic [7:0]       data_byte,
   input  logic             end_of_stream,
   output logic             result_want,
   output result_type       result
);

   phase_type              phase_ff, phase_in;
   logic [4:0]             fin_op_ff, fin_op_in;
   logic                   header_bad_ff, header_bad_in;
   logic [3:0]             ext_count_ff, ext_count_in;
   logic [LEN_W-1:0]       len_acc_ff, len_acc_in;
   logic [3:0][7:0]        mask_key_ff, mask_key_in;
   logic [LEN_W-1:0]       remaining_ff, remaining_in;
   logic [1:0]             mask_idx_ff, mask_idx_in;

   logic [LEN_W-1:0]       remaining_dec;
   logic                   remaining_one;
   logic                   len_zero;
   logic [7:0]             key_byte;
   logic [6:0]             length_code;

   assign remaining_dec = remaining_ff - LEN_W'(1);
   assign remaining_one = (remaining_ff == LEN_W'(1));
   assign len_zero      = (len_acc_ff == '0);
   assign key_byte      = mask_key_ff[~mask_idx_ff];
   assign length_code   = data_byte[6:0];

   // Next-state logic: advance only when the held transaction is consumed
   always_comb begin
      phase_in      = phase_ff;
      fin_op_in     = fin_op_ff;
      header_bad_in = header_bad_ff;
      ext_count_in  = ext_count_ff;
      len_acc_in    = len_acc_ff;
      mask_key_in   = mask_key_ff;
      remaining_in  = remaining_ff;
      mask_idx_in   = mask_idx_ff;
      if (step_en) begin
         unique case (phase_ff)
            PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_PAY: begin
               if (end_of_stream) begin
                  phase_in = PH_HALT;
               end else begin
                  unique case (phase_ff)
                     PH_HDR0: begin
                        fin_op_in     = {data_byte[7], data_byte[3:0]};
                        header_bad_in = (data_byte[6:4] != 3'd0) ||
                                        !opcode_known(data_byte[3:0]);
                        phase_in      = PH_HDR1;
                     end
                     PH_HDR1: begin
                        if (!data_byte[7] || header_bad_ff) begin
                           phase_in = PH_HALT;
                        end else begin
                           mask_idx_in = 2'd0;
                           if (length_code == LEN_CODE_EXT16) begin
                              ext_count_in = EXT16_BYTES;
                              len_acc_in   = '0;
                              phase_in     = PH_EXT;
                           end else if (length_code == LEN_CODE_EXT64) begin
                              ext_count_in = EXT64_BYTES;
                              len_acc_in   = '0;
                              phase_in     = PH_EXT;
                           end else begin
                              ext_count_in = 4'd0;
                              len_acc_in   = LEN_W'(length_code);
                              phase_in     = PH_KEY;
                           end
                        end
                     end
                     PH_EXT: begin
                        len_acc_in   = {len_acc_ff[LEN_W-9:0], data_byte};
                        ext_count_in = ext_count_ff - 4'd1;
                        if (ext_count_ff == 4'd1) begin
                           phase_in = PH_KEY;
                        end
                     end
                     PH_KEY: begin
                        mask_key_in = {mask_key_ff[2:0], data_byte};
                        mask_idx_in = mask_idx_ff + 2'd1;
                        if (mask_idx_ff == 2'd3) begin
                           remaining_in = len_acc_ff;
                           phase_in     = len_zero ? PH_HDR0 : PH_PAY;
                        end
                     end
                     default: begin
                        // payload byte
                        mask_idx_in  = mask_idx_ff + 2'd1;
                        remaining_in = remaining_dec;
                        if (remaining_one) begin
                           phase_in = PH_HDR0;
                        end
                     end
                  endcase
               end
            end
            default: begin
               // halted or unused code: drop everything
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Output logic: decide whether this transaction yields a result
   always_comb begin
      result_want           = 1'b0;
      result.payload_byte   = 8'd0;
      result.kind           = end_of_stream ? KIND_CLOSE : KIND_DATA;
      result.frame_opcode   = fin_op_ff[3:0];
      result.final_fragment = fin_op_ff[4];
      result.last_of_frame  = 1'b0;
      unique case (phase_ff)
         PH_HDR0, PH_EXT: begin
            result_want = end_of_stream;
         end
         PH_HDR1: begin
            result_want = end_of_stream || !data_byte[7] || header_bad_ff;
            if (!end_of_stream) begin
               result.kind = KIND_ERROR;
            end
         end
         PH_KEY: begin
            result_want = end_of_stream || ((mask_idx_ff == 2'd3) && len_zero);
            if (!end_of_stream) begin
               result.kind          = KIND_EMPTY;
               result.last_of_frame = 1'b1;
            end
         end
         PH_PAY: begin
            result_want = 1'b1;
            if (!end_of_stream) begin
               result.payload_byte  = data_byte ^ key_byte;
               result.last_of_frame = remaining_one;
            end
         end
         default: begin
            result_want = 1'b0;
         end
      endcase
   end

   // Hold state; reset clears every state field
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         fin_op_ff     <= 5'd0;
         header_bad_ff <= 1'b0;
         ext_count_ff  <= 4'd0;
         len_acc_ff    <= '0;
         mask_key_ff   <= '0;
         remaining_ff  <= '0;
         mask_idx_ff   <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         fin_op_ff     <= fin_op_in;
         header_bad_ff <= header_bad_in;
         ext_count_ff  <= ext_count_in;
         len_acc_ff    <= len_acc_in;
         mask_key_ff   <= mask_key_in;
         remaining_ff  <= remaining_in;
         mask_idx_ff   <= mask_idx_in;
      end
   end

   // Once halted, the parser never leaves the halted phase
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) |=> (phase_ff == PH_HALT))
      else $error("parser left halted phase");

   // Extension phase always has bytes left to take
   a_ext_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_EXT) |-> (ext_count_ff != 4'd0))
      else $error("extension phase with zero count");

   // Payload phase never runs on an exhausted count
   a_pay_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (remaining_ff != '0))
      else $error("payload phase with nothing remaining");

endmodule

// ===== hw/rtl/wsfd_out_reg.sv =====
// Result register for the deframer output channel.
// Depends on wsfd_pkg.
module wsfd_out_reg import wsfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // Slot frees when empty or when the held transaction leaves this cycle
   assign out_free = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result; hold while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule
